[src/cksum_pkg.sv]
package cksum_pkg;

	localparam logic [1:0] MODE_CRC32 = 2'd0;
	localparam logic [1:0] MODE_ADLER32 = 2'd1;
	localparam logic [1:0] MODE_FNV1A64 = 2'd2;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam logic [15:0] ADLER_LO_INIT = 16'd1;
	localparam logic [15:0] ADLER_HI_INIT = 16'd0;
	localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
	localparam logic [31:0] LENGTH_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic       last_byte;
		logic       byte_present;
		logic [7:0] data_byte;
	} cksum_item_t;

	typedef struct packed {
		logic [31:0] message_length;
		logic [63:0] digest_value;
	} cksum_result_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	// Returns the high sum in the upper half and the low sum in the lower half.
	function automatic logic [31:0] adler_byte(input logic [15:0] lo, input logic [15:0] hi,
			input logic [7:0] b);
		logic [16:0] lo_n;
		logic [16:0] hi_n;
		lo_n = {1'b0, lo} + {9'd0, b};
		if (lo_n >= ADLER_MOD) begin
			lo_n = lo_n - ADLER_MOD;
		end
		hi_n = {1'b0, hi} + lo_n;
		if (hi_n >= ADLER_MOD) begin
			hi_n = hi_n - ADLER_MOD;
		end
		return {hi_n[15:0], lo_n[15:0]};
	endfunction

	// The FNV prime is 2^40 + 0x1B3, so the product is a sum of shifted copies.
	function automatic logic [63:0] fnv1a_byte(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

[src/cksum_engine.sv]
module cksum_engine import cksum_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    mode,
	input  logic          fire,
	input  cksum_item_t   item,
	output cksum_result_t result
);

	logic [31:0] crc_q;
	logic [15:0] adl_lo_q;
	logic [15:0] adl_hi_q;
	logic [63:0] fnv_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic [31:0] crc_nxt;
	logic [31:0] adl_nxt;
	logic [63:0] fnv_nxt;
	logic [COUNT_WIDTH-1:0] count_nxt;
	logic [63:0] count_wide;

	always_comb begin
		crc_nxt = crc_q;
		adl_nxt = {adl_hi_q, adl_lo_q};
		fnv_nxt = fnv_q;
		count_nxt = count_q;
		if (item.byte_present) begin
			crc_nxt = crc32_byte(crc_q, item.data_byte);
			adl_nxt = adler_byte(adl_lo_q, adl_hi_q, item.data_byte);
			fnv_nxt = fnv1a_byte(fnv_q, item.data_byte);
			if (count_q != {COUNT_WIDTH{1'b1}}) begin
				count_nxt = count_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
			end
		end
	end

	assign count_wide = 64'(count_nxt);

	always_comb begin
		unique case (mode)
			MODE_CRC32:   result.digest_value = {32'd0, crc_nxt ^ CRC_INIT};
			MODE_ADLER32: result.digest_value = {32'd0, adl_nxt};
			MODE_FNV1A64: result.digest_value = fnv_nxt;
			default:      result.digest_value = 64'd0;
		endcase
		result.message_length = (count_wide > {32'd0, LENGTH_MAX}) ? LENGTH_MAX
			: count_wide[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			adl_lo_q <= ADLER_LO_INIT;
			adl_hi_q <= ADLER_HI_INIT;
			fnv_q <= FNV_BASIS;
			count_q <= '0;
		end else if (fire) begin
			if (item.last_byte) begin
				crc_q <= CRC_INIT;
				adl_lo_q <= ADLER_LO_INIT;
				adl_hi_q <= ADLER_HI_INIT;
				fnv_q <= FNV_BASIS;
				count_q <= '0;
			end else begin
				crc_q <= crc_nxt;
				adl_lo_q <= adl_nxt[15:0];
				adl_hi_q <= adl_nxt[31:16];
				fnv_q <= fnv_nxt;
				count_q <= count_nxt;
			end
		end
	end

endmodule

[src/cksum_out_stage.sv]
module cksum_out_stage import cksum_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  cksum_result_t result,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output cksum_result_t out_result
);

	logic          valid_q;
	cksum_result_t result_q;

	assign free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			result_q <= result;
		end
	end

endmodule

[src/crc32_adler32_fnv1a_checksum_core.sv]
// Streaming digest engine taking one message byte per beat and computing CRC-32 (IEEE,
// reflected), Adler-32 and FNV-1a 64-bit side by side; cfg_data selects which digest is
// reported (0 CRC-32, 1 Adler-32, 2 FNV-1a 64, 3 reports zero) and should only be written
// while the engine is idle. On s_axis the byte sits in tdata, tuser flags that the byte
// belongs to the message, and tlast closes the message; a closing beat with tuser low
// reports the digest of the bytes seen so far. Each closing beat yields one m_axis beat with
// the digest (32-bit digests zero-extended) in bits 63:0 and the byte count, saturating at
// 2^32-1, in bits 95:64. The engine takes one beat per clock while input is not held back;
// a result reaches m_axis after its closing beat has passed the input register and then the
// result register. A closing beat that waits in the input register behind a stalled result
// holds back all further input until the result register is free.
module crc32_adler32_fnv1a_checksum_core import cksum_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // byte_present
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata   // digest_value[63:0], message_length[95:64]
);

	logic [1:0]    mode_q;
	logic          s1_valid_q;
	cksum_item_t   s1_q;
	logic          s1_adv;
	logic          out_free;
	cksum_result_t eng_result;
	cksum_result_t out_result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CRC32;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	assign s1_adv = s1_valid_q && (!s1_q.last_byte || out_free);
	assign s_axis_tready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			s1_q <= '{last_byte: s_axis_tlast, byte_present: s_axis_tuser,
				data_byte: s_axis_tdata};
		end
	end

	cksum_engine #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.mode(mode_q),
		.fire(s1_adv),
		.item(s1_q),
		.result(eng_result)
	);

	cksum_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(s1_adv && s1_q.last_byte),
		.result(eng_result),
		.free(out_free),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_result(out_result)
	);

	assign m_axis_tdata = {out_result.message_length, out_result.digest_value};

	a_accept_moves_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s1_valid_q) |-> s1_adv)
		else $error("input beat accepted while the input register was held");

	a_close_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && s1_q.last_byte) |=> m_axis_tvalid)
		else $error("closing beat did not produce a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !(s1_adv && s1_q.last_byte))
		else $error("result overwritten while stalled");

endmodule
